### sv/hmac_sha256_engine_defines.svh
// ----------------------------------------------------------------------------
// hmac sha256 engine assertion macros
// concurrent assertion helpers, empty under synthesis
// ----------------------------------------------------------------------------
`ifndef HMAC_SHA256_ENGINE_DEFINES_SVH
`define HMAC_SHA256_ENGINE_DEFINES_SVH
`ifndef SYNTHESIS
`define HSE_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error("%m");
`define HSE_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error("%m");
`else
`define HSE_ASSERT(lbl, clk, rstn, prop)
`define HSE_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

### sv/hse_pkg.sv
// ----------------------------------------------------------------------------
// hse_pkg
// shared types, constants and functions of the hmac sha256 engine
// ----------------------------------------------------------------------------
package hse_pkg;
  localparam int unsigned KeyWords = 8;
  localparam int unsigned KeyIdxW  = 3;
  localparam int unsigned BufDepth = 64;
  localparam logic [7:0]  IpadByte = 8'h36;
  localparam logic [7:0]  OpadByte = 8'h5c;

  localparam logic [31:0] InitH [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

  localparam logic [31:0] RoundK [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
    32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
    32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
    32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
    32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

  // where the 16 message words of a block come from
  typedef enum logic [2:0] {
    SRC_KEY_I,   // key xor ipad
    SRC_BUF,     // block buffer with padding applied
    SRC_ZLEN,    // zeros then length
    SRC_KEY_O,   // key xor opad
    SRC_DIGEST   // inner digest, padding, 768
  } src_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FETCH,    // reading buffer words for a block
    ST_ROUND,    // 64 rounds
    ST_ADD,      // choose the next block after the core's feed-forward add
    ST_EMIT
  } state_e;

  // request from control to the compression core
  typedef struct packed {
    logic        start;
    logic        load_init;
  } core_req_t;

  function automatic logic [31:0] rotr(logic [31:0] x, int unsigned n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction
endpackage

### sv/hse_core.sv
// ----------------------------------------------------------------------------
// hse_core
// sha-256 compression: one round per cycle, schedule in a 16-word window
// ----------------------------------------------------------------------------
module hse_core
  import hse_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  core_req_t    req_i,
  input  logic [511:0] block_i,
  output logic         done_o,
  output logic [255:0] hash_o
);
  logic [31:0] h_q [8];
  logic [31:0] v_q [8];
  logic [31:0] w_q [16];
  logic [6:0]  rnd_q;
  logic        busy_q;

  logic [31:0] t1, t2, s0, s1, wn;
  always_comb begin
    t1 = v_q[7] + (rotr(v_q[4], 6) ^ rotr(v_q[4], 11) ^ rotr(v_q[4], 25)) +
         ((v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6])) + RoundK[rnd_q[5:0]] + w_q[0];
    t2 = (rotr(v_q[0], 2) ^ rotr(v_q[0], 13) ^ rotr(v_q[0], 22)) +
         ((v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]));
    s0 = rotr(w_q[1], 7) ^ rotr(w_q[1], 18) ^ (w_q[1] >> 3);
    s1 = rotr(w_q[14], 17) ^ rotr(w_q[14], 19) ^ (w_q[14] >> 10);
    wn = w_q[0] + s0 + w_q[9] + s1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      rnd_q  <= '0;
      done_o <= 1'b0;
    end else begin
      done_o <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        rnd_q  <= '0;
      end else if (busy_q) begin
        if (rnd_q == 7'd64) begin
          busy_q <= 1'b0;
          done_o <= 1'b1;
        end else begin
          rnd_q <= rnd_q + 7'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      for (int i = 0; i < 16; i++) w_q[i] <= block_i[511 - 32*i -: 32];
      for (int i = 0; i < 8; i++) begin
        v_q[i] <= req_i.load_init ? InitH[i] : h_q[i];
        if (req_i.load_init) h_q[i] <= InitH[i];
      end
    end else if (busy_q) begin
      if (rnd_q == 7'd64) begin
        for (int i = 0; i < 8; i++) h_q[i] <= h_q[i] + v_q[i];
      end else begin
        for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
        w_q[15] <= wn;
        v_q[7] <= v_q[6]; v_q[6] <= v_q[5]; v_q[5] <= v_q[4];
        v_q[4] <= v_q[3] + t1;
        v_q[3] <= v_q[2]; v_q[2] <= v_q[1]; v_q[1] <= v_q[0];
        v_q[0] <= t1 + t2;
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 8; i++) hash_o[255 - 32*i -: 32] = h_q[i];
  end
endmodule

### sv/hmac_sha256_engine.sv
// ----------------------------------------------------------------------------
// hmac_sha256_engine
// hmac-sha256 over a byte stream, mac out as four 64-bit words
// ----------------------------------------------------------------------------
// A byte request is accepted while the engine is idle; s_axis_tready is low
// whenever a block is being hashed. The first request of a message hashes the
// key xor ipad block. The byte that fills the 64-byte buffer first reads the
// buffer back and then hashes it. One compression runs from issue to the next
// step as follows: the request is issued, the core is loaded, the rounds run
// in the single round unit, the feed-forward add follows and then the engine
// chooses what comes next. The end marker runs one or two padding blocks, then
// key xor opad and the digest block: at most four compressions and two buffer
// fetches, after which the four mac words go out one per accepted transfer. The
// message buffer is a 16 x 32-bit synchronous memory written with byte enables
// and read one word per cycle while a block is assembled. Key writes take
// effect immediately; the inner pass latches the ipad key at message start and
// the outer pass reads the key at its end.
// ----------------------------------------------------------------------------
`include "hmac_sha256_engine_defines.svh"
module hmac_sha256_engine
  import hse_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [KeyIdxW-1:0] cfg_idx_i,
  input  logic [63:0]        cfg_wdata_i,
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [7:0]         s_axis_tdata,   // msg_byte
  input  logic               s_axis_tuser,   // byte_present
  input  logic               s_axis_tlast,   // last_byte
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  output logic [63:0]        m_axis_tdata,   // mac_word
  output logic [1:0]         m_axis_tuser,   // word_index
  output logic               m_axis_tlast    // last_word
);
  logic [63:0] key_q [KeyWords];
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < KeyWords; i++) key_q[i] <= '0;
    end else if (cfg_we_i) begin
      key_q[cfg_idx_i] <= cfg_wdata_i;
    end
  end

  // message buffer memory, 16 words of 4 bytes
  logic [31:0] buf_mem [16];
  logic        buf_we;
  logic [3:0]  buf_waddr, buf_raddr;
  logic [1:0]  buf_lane;
  logic [7:0]  buf_wbyte;
  logic [31:0] buf_rdata_q;
  always_ff @(posedge clk_i) begin
    if (buf_we) buf_mem[buf_waddr][31 - 8*buf_lane -: 8] <= buf_wbyte;
    buf_rdata_q <= buf_mem[buf_raddr];
  end

  state_e       state_q, state_d;
  src_e         src_q;
  logic         started_q, last_q, full_q;
  logic [63:0]  len_q;
  logic [4:0]   fcnt_q;
  logic [511:0] blk_q;
  logic [255:0] digest_q;
  logic [1:0]   wcnt_q;
  core_req_t    creq_q;
  logic         cdone;
  logic [255:0] chash;

  hse_core u_core (
    .clk_i, .rst_ni, .req_i(creq_q), .block_i(blk_q), .done_o(cdone), .hash_o(chash)
  );

  logic       acc;
  logic       full_blk;   // accepted byte completes the 64-byte block
  logic [5:0] idx_now;
  assign acc       = s_axis_tvalid && s_axis_tready && (s_axis_tuser || s_axis_tlast);
  assign idx_now   = len_q[8:3];
  assign full_blk  = s_axis_tuser && (idx_now == 6'd63);
  assign buf_we    = acc && s_axis_tuser;
  assign buf_waddr = idx_now[5:2];
  assign buf_lane  = idx_now[1:0];
  assign buf_wbyte = s_axis_tdata;
  assign buf_raddr = fcnt_q[3:0];

  function automatic logic [511:0] key_blk(logic [7:0] pad);
    logic [511:0] r;
    for (int i = 0; i < KeyWords; i++) r[511 - 64*i -: 64] = key_q[i] ^ {8{pad}};
    return r;
  endfunction

  // padded view of a fetched buffer word: bytes beyond the fill are dropped
  logic [31:0] fetch_word;
  always_comb begin
    for (int b = 0; b < 4; b++) begin
      logic [5:0] pos;
      pos = {fcnt_q[3:0] - 4'd1, 2'(b)};
      if (full_q || (pos < idx_now)) fetch_word[31 - 8*b -: 8] = buf_rdata_q[31 - 8*b -: 8];
      else if (pos == idx_now) fetch_word[31 - 8*b -: 8] = 8'h80;
      else fetch_word[31 - 8*b -: 8] = 8'h00;
    end
  end

  logic [63:0] len_pad;
  assign len_pad = len_q + 64'd512;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (acc) begin
          if (!started_q) state_d = ST_ROUND;
          else if (full_blk || s_axis_tlast) state_d = ST_FETCH;
        end
      end
      ST_FETCH: if (fcnt_q == 5'd16) state_d = ST_ROUND;
      ST_ROUND: if (cdone) state_d = ST_ADD;
      ST_ADD: begin
        if (!last_q) begin
          state_d = ST_IDLE;
        end else begin
          unique case (src_q)
            SRC_KEY_I:  state_d = ST_FETCH;
            SRC_BUF:    state_d = full_q ? ST_FETCH : ST_ROUND;
            SRC_DIGEST: state_d = ST_EMIT;
            default:    state_d = ST_ROUND;
          endcase
        end
      end
      ST_EMIT: if (m_axis_tready && (wcnt_q == 2'd3)) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    s_axis_tready = (state_q == ST_IDLE);
    m_axis_tvalid = (state_q == ST_EMIT);
    m_axis_tdata  = chash[255 - 64*wcnt_q -: 64];
    m_axis_tuser  = wcnt_q;
    m_axis_tlast  = (wcnt_q == 2'd3);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      started_q <= 1'b0; last_q <= 1'b0; full_q <= 1'b0;
      len_q <= '0; fcnt_q <= '0; wcnt_q <= '0; src_q <= SRC_KEY_I;
      blk_q <= '0; digest_q <= '0; creq_q <= '0;
    end else begin
      creq_q <= '0;
      unique case (state_q)
        ST_IDLE: begin
          if (acc) begin
            last_q <= s_axis_tlast;
            full_q <= full_blk;
            fcnt_q <= '0;
            if (s_axis_tuser) len_q <= len_q + 64'd8;
            if (!started_q) begin
              started_q <= 1'b1;
              src_q <= SRC_KEY_I;
              blk_q <= key_blk(IpadByte);
              creq_q <= '{start: 1'b1, load_init: 1'b1};
            end else begin
              src_q <= SRC_BUF;
            end
          end
        end
        ST_FETCH: begin
          fcnt_q <= fcnt_q + 5'd1;
          if (fcnt_q == 5'd16) begin
            // a short tail carries the length in its last two words
            if (!full_q && (idx_now < 6'd56)) blk_q[63:0] <= len_pad;
            else blk_q[31:0] <= fetch_word;
            creq_q <= '{start: 1'b1, load_init: 1'b0};
          end else if (fcnt_q != 5'd0) begin
            blk_q[511 - 32*(fcnt_q - 5'd1) -: 32] <= fetch_word;
          end
        end
        ST_ADD: begin
          // choose next block
          if (last_q) begin
            unique case (src_q)
              SRC_KEY_I: begin
                src_q <= SRC_BUF; fcnt_q <= '0;
              end
              SRC_BUF: begin
                if (full_q) begin
                  // message filled the block: padding goes in a block of its own
                  full_q <= 1'b0; fcnt_q <= '0;
                end else if (idx_now >= 6'd56) begin
                  src_q <= SRC_ZLEN; blk_q <= {448'd0, len_pad};
                  creq_q <= '{start: 1'b1, load_init: 1'b0};
                end else begin
                  digest_q <= chash; src_q <= SRC_KEY_O; blk_q <= key_blk(OpadByte);
                  creq_q <= '{start: 1'b1, load_init: 1'b1};
                end
              end
              SRC_ZLEN: begin
                digest_q <= chash; src_q <= SRC_KEY_O; blk_q <= key_blk(OpadByte);
                creq_q <= '{start: 1'b1, load_init: 1'b1};
              end
              SRC_KEY_O: begin
                src_q <= SRC_DIGEST; blk_q <= {digest_q, 8'h80, 184'd0, 64'd768};
                creq_q <= '{start: 1'b1, load_init: 1'b0};
              end
              SRC_DIGEST: begin
                wcnt_q <= '0;
              end
              default: ;
            endcase
          end
        end
        ST_EMIT: begin
          if (m_axis_tready) begin
            wcnt_q <= wcnt_q + 2'd1;
            if (wcnt_q == 2'd3) begin
              started_q <= 1'b0; len_q <= '0; last_q <= 1'b0;
            end
          end
        end
        default: ;
      endcase
    end
  end

  `HSE_ASSERT(a_no_in_while_busy, clk_i, rst_ni, !(s_axis_tready && m_axis_tvalid))
  `HSE_ASSERT_NEXT(a_emit_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready,
                   m_axis_tvalid && $stable(m_axis_tuser))
  `HSE_ASSERT_NEXT(a_start_core, clk_i, rst_ni, creq_q.start, state_q == ST_ROUND)
endmodule
